// ----- src/pla_pkg.sv -----
// Package for the point light distance attenuation block.
// Holds the fixed widths, constants and register indexes; no dependencies.
package pla_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned CoeffW  = 32;
	localparam int unsigned AttenW  = 17;
	localparam int unsigned CoeffFrac = 16;
	localparam int unsigned SumW    = 66;
	localparam int unsigned RootW   = 33;
	localparam int unsigned RemW    = 36;
	localparam int unsigned DenW    = 48;
	localparam int unsigned QuotW   = 16;
	localparam int unsigned AddrW   = 5;

	localparam logic [DenW-1:0]   DenMax = {DenW{1'b1}};
	localparam logic [DenW-1:0]   OneQ16 = DenW'(65536);
	localparam logic [AttenW-1:0] AttenOne = AttenW'(65536);

	typedef enum logic [2:0] {
		REG_LIGHT_X   = 3'd0,
		REG_LIGHT_Y   = 3'd1,
		REG_LIGHT_Z   = 3'd2,
		REG_CONSTANT  = 3'd3,
		REG_LINEAR    = 3'd4,
		REG_QUADRATIC = 3'd5
	} reg_idx_t;

endpackage

// ----- src/point_light_distance_attenuation.sv -----
// One point accepted every cycle.
// Throughput set by a fully pipelined datapath: 33 square root stages
// (one root bit each) and 16 divider stages (one quotient bit each).
// busy is always low; done strobes for one cycle with attenuation.
// arst_n clears valid bits and loads register reset values.
// Top level; uses pla_pkg.
module point_light_distance_attenuation #(
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pla_pkg::AddrW-1:0]      paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [pla_pkg::CoordW-1:0] point_x,
	input  logic signed [pla_pkg::CoordW-1:0] point_y,
	input  logic signed [pla_pkg::CoordW-1:0] point_z,
	output logic                           done,
	output logic [pla_pkg::AttenW-1:0]     attenuation
);
	import pla_pkg::*;

	localparam int unsigned ShL = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
	localparam int unsigned ShR = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
	localparam int unsigned DW  = RootW + ShL;
	localparam int unsigned HW  = DW - 32;
	localparam int unsigned SqStg = RootW;

	// configuration registers
	logic signed [CoordW-1:0] light_x_q, light_y_q, light_z_q;
	logic [CoeffW-1:0] const_q, lin_c_q, quad_c_q;
	logic [2:0] ridx;

	assign ridx   = paddr[4:2];
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= '0;
			const_q   <= CoeffW'(65536);
			lin_c_q   <= '0;
			quad_c_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_LIGHT_X:   light_x_q <= pwdata;
				REG_LIGHT_Y:   light_y_q <= pwdata;
				REG_LIGHT_Z:   light_z_q <= pwdata;
				REG_CONSTANT:  const_q   <= pwdata;
				REG_LINEAR:    lin_c_q   <= pwdata;
				REG_QUADRATIC: quad_c_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_LIGHT_X:   prdata = light_x_q;
			REG_LIGHT_Y:   prdata = light_y_q;
			REG_LIGHT_Z:   prdata = light_z_q;
			REG_CONSTANT:  prdata = const_q;
			REG_LINEAR:    prdata = lin_c_q;
			REG_QUADRATIC: prdata = quad_c_q;
			default:       prdata = '0;
		endcase
	end

	// stage 1: absolute differences
	logic signed [CoordW:0] dx, dy, dz;
	logic [CoordW-1:0] ax_s1, ay_s1, az_s1;
	logic v_s1;
	assign dx = 33'(point_x) - 33'(light_x_q);
	assign dy = 33'(point_y) - 33'(light_y_q);
	assign dz = 33'(point_z) - 33'(light_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ax_s1 <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
		ay_s1 <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
		az_s1 <= dz[CoordW] ? CoordW'(-dz) : dz[CoordW-1:0];
	end

	// stage 2: squares
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		sx_s2 <= ax_s1 * ax_s1;
		sy_s2 <= ay_s1 * ay_s1;
		sz_s2 <= az_s1 * az_s1;
	end

	// stage 3: sum of squares
	logic [SumW-1:0] sum_s3;
	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		sum_s3 <= SumW'(sx_s2) + SumW'(sy_s2) + SumW'(sz_s2);
	end

	// square root: one root bit per stage, most significant pair first
	logic [SumW-1:0]  sq_rad_s  [0:SqStg];
	logic [RemW-1:0]  sq_rem_s  [0:SqStg];
	logic [RootW-1:0] sq_root_s [0:SqStg];
	logic             sq_v_s    [0:SqStg];

	assign sq_rad_s[0]  = sum_s3;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_v_s[0]    = v_s3;

	for (genvar k = 0; k < SqStg; k++) begin : g_sqrt
		logic [RemW-1:0] rn, tr;
		assign rn = {sq_rem_s[k][RemW-3:0], sq_rad_s[k][SumW-1-2*k -: 2]};
		assign tr = {1'b0, sq_root_s[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else sq_v_s[k+1] <= sq_v_s[k];
		end
		always_ff @(posedge clk) begin
			sq_rad_s[k+1] <= sq_rad_s[k];
			if (rn >= tr) begin
				sq_rem_s[k+1]  <= rn - tr;
				sq_root_s[k+1] <= {sq_root_s[k][RootW-2:0], 1'b1};
			end else begin
				sq_rem_s[k+1]  <= rn;
				sq_root_s[k+1] <= {sq_root_s[k][RootW-2:0], 1'b0};
			end
		end
	end

	// distance scaled to 16 fraction bits
	logic [DW-1:0] d16_s4;
	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= sq_v_s[SqStg];
	end
	always_ff @(posedge clk) begin
		d16_s4 <= (DW'(sq_root_s[SqStg]) << ShL) >> ShR;
	end

	// stage 5: partial products for linear term and distance squared
	logic [63:0]      lin_lo_s5, dd_ll_s5;
	logic [32+HW-1:0] lin_hi_s5, dd_hl_s5;
	logic [2*HW-1:0]  dd_hh_s5;
	logic v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		lin_lo_s5 <= lin_c_q * d16_s4[31:0];
		lin_hi_s5 <= lin_c_q * d16_s4[DW-1:32];
		dd_ll_s5  <= d16_s4[31:0] * d16_s4[31:0];
		dd_hl_s5  <= d16_s4[DW-1:32] * d16_s4[31:0];
		dd_hh_s5  <= d16_s4[DW-1:32] * d16_s4[DW-1:32];
	end

	// stage 6: combine, saturate at 2^64-1, drop 16 fraction bits
	localparam int unsigned LinW = 32 + DW + 1;
	localparam int unsigned SqW  = 2 * DW + 2;
	logic [LinW-1:0] lin_full;
	logic [SqW-1:0]  dd_full;
	logic [DenW-1:0] lin_s6, d2_s6;
	logic v_s6;
	assign lin_full = (LinW'(lin_hi_s5) << 32) + LinW'(lin_lo_s5);
	assign dd_full  = (SqW'(dd_hh_s5) << 64) + (SqW'(dd_hl_s5) << 33) + SqW'(dd_ll_s5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		lin_s6 <= (|lin_full[LinW-1:64]) ? DenMax : lin_full[63:16];
		d2_s6  <= (|dd_full[SqW-1:64]) ? DenMax : dd_full[63:16];
	end

	// stage 7: quadratic partial products
	logic [63:0]     qd_lo_s7;
	logic [47:0]     qd_hi_s7;
	logic [DenW-1:0] lin_s7;
	logic v_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		qd_lo_s7 <= quad_c_q * d2_s6[31:0];
		qd_hi_s7 <= quad_c_q * d2_s6[47:32];
		lin_s7   <= lin_s6;
	end

	// stage 8: quadratic term and constant plus linear
	logic [80:0]     qd_full;
	logic [DenW-1:0] quad_s8;
	logic [DenW:0]   cl_s8;
	logic v_s8;
	assign qd_full = (81'(qd_hi_s7) << 32) + 81'(qd_lo_s7);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		quad_s8 <= (|qd_full[80:64]) ? DenMax : qd_full[63:16];
		cl_s8   <= (DenW+1)'(const_q) + (DenW+1)'(lin_s7);
	end

	// stage 9: saturated denominator
	logic [DenW+1:0] den_full;
	logic [DenW-1:0] den_s9;
	logic v_s9;
	assign den_full = (DenW+2)'(cl_s8) + (DenW+2)'(quad_s8);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		den_s9 <= (|den_full[DenW+1:DenW]) ? DenMax : den_full[DenW-1:0];
	end

	// divider: 2^32 / den, one quotient bit per stage
	logic [DenW-1:0]  dv_den_s [0:QuotW];
	logic [DenW-1:0]  dv_rem_s [0:QuotW];
	logic [QuotW-1:0] dv_q_s   [0:QuotW];
	logic             dv_one_s [0:QuotW];
	logic             dv_v_s   [0:QuotW];

	assign dv_den_s[0] = den_s9;
	assign dv_rem_s[0] = OneQ16;
	assign dv_q_s[0]   = '0;
	assign dv_one_s[0] = (den_s9 <= OneQ16);
	assign dv_v_s[0]   = v_s9;

	for (genvar j = 0; j < QuotW; j++) begin : g_div
		logic [DenW:0] r2;
		assign r2 = {dv_rem_s[j], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			dv_den_s[j+1] <= dv_den_s[j];
			dv_one_s[j+1] <= dv_one_s[j];
			if (!dv_one_s[j] && r2 >= {1'b0, dv_den_s[j]}) begin
				dv_rem_s[j+1] <= DenW'(r2 - {1'b0, dv_den_s[j]});
				dv_q_s[j+1]   <= {dv_q_s[j][QuotW-2:0], 1'b1};
			end else begin
				dv_rem_s[j+1] <= r2[DenW-1:0];
				dv_q_s[j+1]   <= {dv_q_s[j][QuotW-2:0], 1'b0};
			end
		end
	end

	// output word
	logic done_q;
	logic [AttenW-1:0] atten_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv_v_s[QuotW];
	end
	always_ff @(posedge clk) begin
		atten_q <= dv_one_s[QuotW] ? AttenOne : {1'b0, dv_q_s[QuotW]};
	end

	assign done        = done_q;
	assign attenuation = atten_q;

endmodule

// ----- sim/tb_point_light_distance_attenuation.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for point_light_distance_attenuation.
// Drives points and APB register writes, predicts attenuation in the bench; uses pla_pkg.
module tb_point_light_distance_attenuation;
	import pla_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam int unsigned LATENCY = 59;
	localparam int unsigned LIMIT = 400000;
	localparam int unsigned PHASES = 9;
	localparam logic [63:0] SAT64 = {64{1'b1}};

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy, done;
	logic signed [CoordW-1:0] point_x, point_y, point_z;
	logic [AttenW-1:0] attenuation;

	// directed stimulus row; typed-in value is used when fixed is set
	typedef struct {
		int unsigned phase;
		logic [31:0] x, y, z;
		bit fixed;
		logic [AttenW-1:0] atten;
	} point_row_t;

	// bench copy of the registers
	logic signed [31:0] light_x, light_y, light_z;
	logic [31:0] const_c, lin_c, quad_c;

	logic [AttenW-1:0] atten_q[$];
	bit row_fixed;
	logic [AttenW-1:0] row_atten;
	int unsigned errors, n_points, n_words, cycles;

	point_light_distance_attenuation #(
		.COORD_FRAC_BITS(FRAC)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .attenuation(attenuation)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root of a 66-bit sum, one root bit per step
	function automatic logic [32:0] isqrt(input logic [65:0] s);
		logic [67:0] rem, trial;
		logic [32:0] root;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'((s >> (2 * i)) & 66'd3);
			trial = (68'(root) << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 33'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic [63:0] sat64(input logic [127:0] p);
		return (p > 128'(SAT64)) ? SAT64 : p[63:0];
	endfunction

	function automatic logic [AttenW-1:0] atten_of(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		logic signed [33:0] dx, dy, dz;
		logic [32:0] ax, ay, az, d;
		logic [65:0] s;
		logic [63:0] d16, lin, d2, quad, den;
		dx = 34'(px) - 34'(light_x);
		dy = 34'(py) - 34'(light_y);
		dz = 34'(pz) - 34'(light_z);
		ax = (dx < 0) ? 33'(-dx) : 33'(dx);
		ay = (dy < 0) ? 33'(-dy) : 33'(dy);
		az = (dz < 0) ? 33'(-dz) : 33'(dz);
		s = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
		d = isqrt(s);
		// distance rescaled to 16 fraction bits
		if (FRAC >= 16) d16 = 64'(d) >> (FRAC - 16);
		else d16 = 64'(d) << (16 - FRAC);
		lin = sat64(128'(lin_c) * 128'(d16)) >> CoeffFrac;
		d2 = sat64(128'(d16) * 128'(d16)) >> CoeffFrac;
		quad = sat64(128'(quad_c) * 128'(d2)) >> CoeffFrac;
		den = 64'(const_c);
		if (lin >= 64'(DenMax) - den) den = 64'(DenMax);
		else den = den + lin;
		if (quad >= 64'(DenMax) - den) den = 64'(DenMax);
		else den = den + quad;
		if (den <= 64'(OneQ16)) return AttenOne;
		return AttenW'((64'd1 << 32) / den);
	endfunction

	task automatic report(input string what, input logic [AttenW-1:0] got,
			input logic [AttenW-1:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
	endtask

	// accept and compare at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				atten_q.push_back(row_fixed ? row_atten : atten_of(point_x, point_y, point_z));
				n_points++;
			end
			if (done) begin
				if (atten_q.size() == 0) report("unexpected word", attenuation, '0);
				else begin
					logic [AttenW-1:0] want;
					want = atten_q.pop_front();
					if (attenuation !== want) report("attenuation", attenuation, want);
				end
				n_words++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LIGHT_X:   light_x = val;
			REG_LIGHT_Y:   light_y = val;
			REG_LIGHT_Z:   light_z = val;
			REG_CONSTANT:  const_c = val;
			REG_LINEAR:    lin_c = val;
			REG_QUADRATIC: quad_c = val;
			default: ;
		endcase
	endtask

	function automatic int unsigned pick_gap(input bit burst);
		int unsigned r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one point, hold until accepted
	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input bit fixed, input logic [AttenW-1:0] want,
			input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		row_fixed <= fixed;
		row_atten <= want;
		do @(posedge clk); while (busy);
	endtask

	// coordinate near the light, in a mid range, or anywhere
	function automatic logic [31:0] rand_coord(input logic [31:0] center);
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r < 2) return center + 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
		if (r == 2) return center + 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
		return $urandom;
	endfunction

	point_row_t rows[$];

	initial begin
		bit burst;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; point_x = '0; point_y = '0; point_z = '0;
		row_fixed = 1'b0; row_atten = '0;
		errors = 0; n_points = 0; n_words = 0; cycles = 0;
		light_x = '0; light_y = '0; light_z = '0;
		const_c = 32'd65536; lin_c = '0; quad_c = '0;

		// after reset the denominator is 1.0 whatever the point
		rows.push_back('{0, 32'h0, 32'h0, 32'h0, 1'b1, AttenOne});
		rows.push_back('{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, AttenOne});
		rows.push_back('{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, AttenOne});
		rows.push_back('{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, AttenOne});
		rows.push_back('{0, 32'hFFFF_FFFF, 32'h0001_0000, 32'hAAAA_5555, 1'b1, AttenOne});
		// all coefficients at max, light at the negative corner
		rows.push_back('{1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
		rows.push_back('{1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '0});
		rows.push_back('{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
		rows.push_back('{1, 32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
		// zero coefficients: denominator zero
		rows.push_back('{2, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, AttenOne});
		rows.push_back('{2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, AttenOne});
		// constant just above 1.0, points on and next to the light
		rows.push_back('{3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
		rows.push_back('{3, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			// registers change only with nothing in flight
			case (ph)
				0: ;
				1: begin
					reg_write(REG_LIGHT_X, 32'h8000_0000);
					reg_write(REG_LIGHT_Y, 32'h8000_0000);
					reg_write(REG_LIGHT_Z, 32'h8000_0000);
					reg_write(REG_CONSTANT, 32'hFFFF_FFFF);
					reg_write(REG_LINEAR, 32'hFFFF_FFFF);
					reg_write(REG_QUADRATIC, 32'hFFFF_FFFF);
				end
				2: begin
					reg_write(REG_LIGHT_X, 32'h7FFF_FFFF);
					reg_write(REG_LIGHT_Y, 32'h0);
					reg_write(REG_LIGHT_Z, 32'h8000_0000);
					reg_write(REG_CONSTANT, 32'h0);
					reg_write(REG_LINEAR, 32'h0);
					reg_write(REG_QUADRATIC, 32'h0);
				end
				3: begin
					reg_write(REG_LIGHT_X, 32'h7FFF_FFFF);
					reg_write(REG_LIGHT_Y, 32'h7FFF_FFFF);
					reg_write(REG_LIGHT_Z, 32'h7FFF_FFFF);
					reg_write(REG_CONSTANT, 32'h0001_0001);
					reg_write(REG_LINEAR, 32'h0000_4000);
					reg_write(REG_QUADRATIC, 32'h0000_0100);
				end
				default: begin
					reg_write(REG_LIGHT_X, $urandom_range(0, 3) == 0 ? $urandom :
						32'($signed($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000));
					reg_write(REG_LIGHT_Y, $urandom);
					reg_write(REG_LIGHT_Z, 32'($signed($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000));
					reg_write(REG_CONSTANT, $urandom_range(0, 4) == 0 ? $urandom :
						$urandom_range(0, 32'h2_0000));
					reg_write(REG_LINEAR, $urandom_range(0, 4) == 0 ? $urandom :
						$urandom_range(0, 32'h4_0000));
					reg_write(REG_QUADRATIC, $urandom_range(0, 4) == 0 ? $urandom :
						$urandom_range(0, 32'h1_0000));
				end
			endcase

			burst = ($urandom_range(0, 2) == 0);
			foreach (rows[i])
				if (rows[i].phase == ph)
					send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].fixed,
						rows[i].atten, pick_gap(burst));
			repeat (68) begin
				if ($urandom_range(0, 19) == 0) burst = ~burst;
				send_point(rand_coord(light_x), rand_coord(light_y), rand_coord(light_z),
					1'b0, '0, pick_gap(burst));
			end
			start <= 1'b0;
			@(posedge clk);
			while (atten_q.size() != 0) @(posedge clk);
			repeat (LATENCY + 10) @(posedge clk);
		end

		$display("%0d points sent over %0d register settings, %0d attenuation words checked",
			n_points, PHASES, n_words);
		$display("%0d mismatches; %0d words still expected", errors, atten_q.size());
		if (errors == 0 && atten_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
